// ===== sv/vmrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vmrs_pkg
// Shared types and constants of the virtio-mmio register stub: register
// offsets, fixed read values, access codes and the access control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package vmrs_pkg;

   // access kind
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // access width codes; code 3 behaves as a word
   typedef enum logic [1:0] {
      SIZE_BYTE = 2'd0,
      SIZE_HALF = 2'd1,
      SIZE_WORD = 2'd2
   } vmrs_size_type;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT0_BASE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT1_BASE = 8'd1;

   localparam logic [31:0] SLOT0_BASE_RESET = 32'h1000_1000;
   localparam logic [31:0] SLOT1_BASE_RESET = 32'h1000_1200;

   // fixed read values ("virt", version, vendor)
   localparam logic [31:0] MAGIC_WORD   = 32'h7472_6976;
   localparam logic [31:0] VERSION_WORD = 32'h0000_0002;
   localparam logic [31:0] VENDOR_WORD  = 32'h4F52_4C58;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

   // register offsets within a slot window
   localparam logic [7:0] OFF_MAGIC        = 8'h00;
   localparam logic [7:0] OFF_VERSION      = 8'h04;
   localparam logic [7:0] OFF_DEVICE_ID    = 8'h08;
   localparam logic [7:0] OFF_VENDOR_ID    = 8'h0C;
   localparam logic [7:0] OFF_DEV_FEAT_SEL = 8'h14;
   localparam logic [7:0] OFF_DRV_FEAT     = 8'h20;
   localparam logic [7:0] OFF_DRV_FEAT_SEL = 8'h24;
   localparam logic [7:0] OFF_QUEUE_SEL    = 8'h30;
   localparam logic [7:0] OFF_QUEUE_NUM    = 8'h38;
   localparam logic [7:0] OFF_QUEUE_READY  = 8'h44;
   localparam logic [7:0] OFF_STATUS       = 8'h70;
   localparam logic [7:0] OFF_DESC_LOW     = 8'h80;
   localparam logic [7:0] OFF_DESC_HIGH    = 8'h84;
   localparam logic [7:0] OFF_AVAIL_LOW    = 8'h90;
   localparam logic [7:0] OFF_AVAIL_HIGH   = 8'h94;
   localparam logic [7:0] OFF_USED_LOW     = 8'hA0;
   localparam logic [7:0] OFF_USED_HIGH    = 8'hA4;
   localparam logic [7:0] OFF_SHM_SEL      = 8'hAC;
   localparam logic [7:0] OFF_SHM_LEN_LOW  = 8'hB0;
   localparam logic [7:0] OFF_SHM_LEN_HIGH = 8'hB4;

   // ring address word positions per slot
   localparam int RING_WORDS = 6;
   localparam int RING_DESC_LOW   = 0;
   localparam int RING_DESC_HIGH  = 1;
   localparam int RING_AVAIL_LOW  = 2;
   localparam int RING_AVAIL_HIGH = 3;
   localparam int RING_USED_LOW   = 4;
   localparam int RING_USED_HIGH  = 5;

   // one decoded access, passed from decode to the register file
   typedef struct packed {
      logic          wr_en;     // write that hit a window
      logic          slot;      // slot that was hit
      vmrs_size_type size;
      logic [1:0]    byte_sel;  // address[1:0]
   } vmrs_acc_type;

endpackage

`default_nettype wire

// ===== sv/vmrs_decode.sv =====
// ----------------------------------------------------------------------------
// vmrs_decode
// Slot window decode: effective address, slot hit and byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

module vmrs_decode
   import vmrs_pkg::*;
#(
   parameter int NUM_SLOTS = 2,
   parameter int SLOT_SPAN = 512,
   parameter int OFF_W     = $clog2(SLOT_SPAN)
) (
   input  wire logic [31:0]      address,
   input  wire logic [1:0]       access_size,
   input  wire logic [31:0]      slot0_base,
   input  wire logic [31:0]      slot1_base,
   output      logic             hit,
   output      logic             slot,
   output      logic [OFF_W-1:0] offset
);

   logic [31:0] eff;
   logic [32:0] end0, end1;
   logic        hit0, hit1;
   logic [31:0] off0, off1;

   // sub-word accesses decode on the word address
   always_comb begin
      case (access_size)
         SIZE_BYTE, SIZE_HALF: eff = {address[31:2], 2'b00};
         default:              eff = address;
      endcase
   end

   // window ends are taken in 33 bits so they never wrap
   assign end0 = {1'b0, slot0_base} + 33'(SLOT_SPAN);
   assign end1 = {1'b0, slot1_base} + 33'(SLOT_SPAN);
   assign hit0 = (eff >= slot0_base) && ({1'b0, eff} < end0);
   assign hit1 = (NUM_SLOTS > 1) && (eff >= slot1_base) && ({1'b0, eff} < end1);
   assign off0 = eff - slot0_base;
   assign off1 = eff - slot1_base;

   // slot 0 wins where windows overlap
   always_comb begin
      hit    = hit0 || hit1;
      slot   = !hit0 && hit1;
      offset = hit0 ? off0[OFF_W-1:0] : off1[OFF_W-1:0];
   end

endmodule

`default_nettype wire

// ===== sv/vmrs_regfile.sv =====
// ----------------------------------------------------------------------------
// vmrs_regfile
// Per-slot device registers, word read mux and sub-word write merge.
// ----------------------------------------------------------------------------
`default_nettype none

module vmrs_regfile
   import vmrs_pkg::*;
#(
   parameter int NUM_SLOTS = 2,
   parameter int OFF_W     = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire vmrs_acc_type     acc,
   input  wire logic [OFF_W-1:0] offset,
   input  wire logic [31:0]      write_data,
   output      logic [31:0]      read_data
);

   logic [7:0]  status_ff       [NUM_SLOTS];
   logic [31:0] dev_feat_sel_ff [NUM_SLOTS];
   logic [31:0] drv_feat_sel_ff [NUM_SLOTS];
   logic [31:0] drv_feat_ff     [NUM_SLOTS][2];
   logic [31:0] queue_sel_ff    [NUM_SLOTS];
   logic [31:0] queue_num_ff    [NUM_SLOTS];
   logic        queue_ready_ff  [NUM_SLOTS];
   logic [31:0] ring_ff         [NUM_SLOTS][RING_WORDS];
   logic [31:0] shm_sel_ff      [NUM_SLOTS];

   logic [31:0] slot_word [NUM_SLOTS];
   logic [31:0] word, mask, merged;
   logic [4:0]  shift;

   // word read for every slot
   always_comb begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
         case (offset)
            OFF_W'(OFF_MAGIC):        slot_word[s] = MAGIC_WORD;
            OFF_W'(OFF_VERSION):      slot_word[s] = VERSION_WORD;
            OFF_W'(OFF_VENDOR_ID):    slot_word[s] = VENDOR_WORD;
            OFF_W'(OFF_QUEUE_NUM):    slot_word[s] = queue_num_ff[s];
            OFF_W'(OFF_QUEUE_READY):  slot_word[s] = {31'd0, queue_ready_ff[s]};
            OFF_W'(OFF_STATUS):       slot_word[s] = {24'd0, status_ff[s]};
            OFF_W'(OFF_DESC_LOW):     slot_word[s] = ring_ff[s][RING_DESC_LOW];
            OFF_W'(OFF_DESC_HIGH):    slot_word[s] = ring_ff[s][RING_DESC_HIGH];
            OFF_W'(OFF_AVAIL_LOW):    slot_word[s] = ring_ff[s][RING_AVAIL_LOW];
            OFF_W'(OFF_AVAIL_HIGH):   slot_word[s] = ring_ff[s][RING_AVAIL_HIGH];
            OFF_W'(OFF_USED_LOW):     slot_word[s] = ring_ff[s][RING_USED_LOW];
            OFF_W'(OFF_USED_HIGH):    slot_word[s] = ring_ff[s][RING_USED_HIGH];
            OFF_W'(OFF_SHM_LEN_LOW),
            OFF_W'(OFF_SHM_LEN_HIGH): slot_word[s] = ALL_ONES;
            default:                  slot_word[s] = '0;
         endcase
      end
   end

   always_comb begin
      word = slot_word[0];
      for (int s = 1; s < NUM_SLOTS; s++) begin
         if (acc.slot == 1'(s)) begin
            word = slot_word[s];
         end
      end
   end

   // lane select and merge
   always_comb begin
      case (acc.size)
         SIZE_BYTE: begin
            mask  = 32'h0000_00FF;
            shift = {acc.byte_sel, 3'b000};
         end
         SIZE_HALF: begin
            mask  = 32'h0000_FFFF;
            shift = {acc.byte_sel[1], 4'b0000};
         end
         default: begin
            mask  = ALL_ONES;
            shift = 5'd0;
         end
      endcase
      read_data = (word >> shift) & mask;
      merged    = (word & ~(mask << shift)) | ((write_data & mask) << shift);
   end

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            status_ff[s]       <= '0;
            dev_feat_sel_ff[s] <= '0;
            drv_feat_sel_ff[s] <= '0;
            drv_feat_ff[s][0]  <= '0;
            drv_feat_ff[s][1]  <= '0;
            queue_sel_ff[s]    <= '0;
            queue_num_ff[s]    <= '0;
            queue_ready_ff[s]  <= 1'b0;
            shm_sel_ff[s]      <= '0;
            for (int k = 0; k < RING_WORDS; k++) begin
               ring_ff[s][k] <= '0;
            end
         end else if (acc.wr_en && (acc.slot == 1'(s))) begin
            case (offset)
               OFF_W'(OFF_DEV_FEAT_SEL): dev_feat_sel_ff[s] <= merged;
               OFF_W'(OFF_DRV_FEAT): begin
                  // only selectors 0 and 1 address a stored word
                  if (drv_feat_sel_ff[s][31:1] == '0) begin
                     drv_feat_ff[s][drv_feat_sel_ff[s][0]] <= merged;
                  end
               end
               OFF_W'(OFF_DRV_FEAT_SEL): drv_feat_sel_ff[s] <= merged;
               OFF_W'(OFF_QUEUE_SEL):    queue_sel_ff[s]    <= merged;
               OFF_W'(OFF_QUEUE_NUM):    queue_num_ff[s]    <= merged;
               OFF_W'(OFF_QUEUE_READY):  queue_ready_ff[s]  <= (merged != '0);
               OFF_W'(OFF_STATUS):       status_ff[s]       <= merged[7:0];
               OFF_W'(OFF_SHM_SEL):      shm_sel_ff[s]      <= merged;
               OFF_W'(OFF_DESC_LOW):     ring_ff[s][RING_DESC_LOW]   <= merged;
               OFF_W'(OFF_DESC_HIGH):    ring_ff[s][RING_DESC_HIGH]  <= merged;
               OFF_W'(OFF_AVAIL_LOW):    ring_ff[s][RING_AVAIL_LOW]  <= merged;
               OFF_W'(OFF_AVAIL_HIGH):   ring_ff[s][RING_AVAIL_HIGH] <= merged;
               OFF_W'(OFF_USED_LOW):     ring_ff[s][RING_USED_LOW]   <= merged;
               OFF_W'(OFF_USED_HIGH):    ring_ff[s][RING_USED_HIGH]  <= merged;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/virtio_mmio_register_stub.sv =====
// ----------------------------------------------------------------------------
// virtio_mmio_register_stub
// Stub virtio-mmio version 2 register window for up to two device slots.
// ----------------------------------------------------------------------------
// One bus access (byte, halfword or word read or write) per transfer on the
// req_ channel gives exactly one transfer on the rsp_ channel, in order. An
// access is taken into an input register, decoded and served in a single
// pass of combinational logic, and its result lands in the result register,
// from which the response is offered on the rsp_ channel. The block sustains
// one access per cycle while rsp_ready stays high; a stalled response holds
// the input register and then blocks req_ready. The register file update
// and the result register load happen on the same edge.
// Each slot window spans SLOT_SPAN bytes at a base set through the csr_
// port (index 0 slot 0, index 1 slot 1, other indexes dropped); slot 0 is
// tested first. Write the bases only while no access is in flight.
// rsp_hit reports a window hit; rsp_read_data is zero for writes and misses.
// ----------------------------------------------------------------------------
`default_nettype none

module virtio_mmio_register_stub
   import vmrs_pkg::*;
#(
   parameter int NUM_SLOTS = 2,
   parameter int SLOT_SPAN = 512
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic                 req_type,
   input  wire logic [31:0]          req_address,
   input  wire logic [1:0]           req_access_size,
   input  wire logic [31:0]          req_write_data,
   // response channel
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic                 rsp_hit,
   output      logic [31:0]          rsp_read_data,
   // configuration channel
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   localparam int OFF_W = $clog2(SLOT_SPAN);

   logic [31:0] base0_ff, base1_ff;

   // input register
   logic        s1_valid_ff;
   logic        s1_type_ff;
   logic [31:0] s1_address_ff;
   logic [1:0]  s1_size_ff;
   logic [31:0] s1_wdata_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_hit_ff;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;

   logic             advance;
   logic             dec_hit, dec_slot;
   logic [OFF_W-1:0] dec_offset;
   logic [31:0]      rf_read_data;
   vmrs_acc_type     acc;

   // ---- configuration: always ready, writes land at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base0_ff <= SLOT0_BASE_RESET;
         base1_ff <= SLOT1_BASE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SLOT0_BASE: base0_ff <= csr_data;
            CSR_SLOT1_BASE: base1_ff <= csr_data;
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   // ---- pipeline control
   // The held access is served when the result register is free or is
   // handing its transfer over in this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // hold the payload until the next transfer
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff    <= req_type;
         s1_address_ff <= req_address;
         s1_size_ff    <= req_access_size;
         s1_wdata_ff   <= req_write_data;
      end
   end

   // ---- decode and register file, one pass
   vmrs_decode #(
      .NUM_SLOTS (NUM_SLOTS),
      .SLOT_SPAN (SLOT_SPAN),
      .OFF_W     (OFF_W)
   ) u_decode (
      .address     (s1_address_ff),
      .access_size (s1_size_ff),
      .slot0_base  (base0_ff),
      .slot1_base  (base1_ff),
      .hit         (dec_hit),
      .slot        (dec_slot),
      .offset      (dec_offset)
   );

   always_comb begin
      acc.wr_en    = advance && dec_hit && (s1_type_ff == REQ_WRITE);
      acc.slot     = dec_slot;
      acc.size     = vmrs_size_type'(s1_size_ff);
      acc.byte_sel = s1_address_ff[1:0];
   end

   vmrs_regfile #(
      .NUM_SLOTS (NUM_SLOTS),
      .OFF_W     (OFF_W)
   ) u_regfile (
      .clock      (clock),
      .reset      (reset),
      .acc        (acc),
      .offset     (dec_offset),
      .write_data (s1_wdata_ff),
      .read_data  (rf_read_data)
   );

   // reads that hit return data; writes and misses return zero
   assign rsp_data_in = (dec_hit && (s1_type_ff == REQ_READ)) ? rf_read_data : '0;

   // ---- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff  <= dec_hit;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_read_data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a served access always leaves a result behind
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("served access did not load the result register");

   // a stalled result with a held access must block new requests
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && s1_valid_ff) |-> !req_ready)
      else $error("request taken while both stages are stalled");

   // a miss never carries data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_data_ff == '0))
      else $error("miss result with non-zero data");
`endif

endmodule

`default_nettype wire
